FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fsp_pkg.sv
`default_nettype none

package fsp_pkg;

	// Upper bound of the zero-pad width
	localparam int MAX_WIDTH_DEF = 64;

	// Digits produced at most for one number
	localparam logic [3:0] NUM_DIGITS = 4'd10;

	// floor(x / 10) == (x * RECIP10) >> 35 for every 32-bit x
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_X     = 8'h78;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR1,
		ST_CHAR2,
		ST_MUL,
		ST_DIG,
		ST_FIN,
		ST_PAD,
		ST_OUT
	} fsp_state_t;

	// Map a digit value to its uppercase ASCII code
	function automatic logic [7:0] hex_ascii(input logic [3:0] d);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		return (d < 4'd10) ? (CH_0 + d8) : (CH_UA - 8'd10 + d8);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/format_string_printer.sv
// Channel  | handshake              | payload
// ---------+------------------------+------------------------
// input    | in_valid / in_stall    | fmt_char, arg_value
// output   | out_valid / out_stall  | out_byte, last
//
// One format word is taken only while the sequencer is idle; in_stall is high while it works.
// Each word is taken while idle; '%' and width digits leave the sequencer idle.
// Plain, %c, %% and terminator print one byte from CHAR1; unknown conversions give two, from CHAR1 and CHAR2.
// %d sends each digit through the reciprocal multiply (MUL) and then DIG; %x/%p through DIG alone.
// A number then sets up in FIN and sends its pad zeros from PAD and its digit bytes from OUT.
// out_stall holds the output register and the emitting states; arst_n clears the control registers.
`default_nettype none

module format_string_printer #(
	parameter int MAX_WIDTH = fsp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  fmt_char,
	input  wire logic [31:0] arg_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	localparam int PW = $clog2(MAX_WIDTH + 1);

	fsp_pkg::fsp_state_t state_q, state_d;

	logic          after_q;
	logic [PW-1:0] pad_q;
	logic [PW-1:0] pw_q;
	logic [PW-1:0] pad_rem_q;
	logic [3:0]    cnt_q;
	logic [31:0]   x_q;
	logic [28:0]   quo_q;
	logic          neg_q;
	logic          hex_q;
	logic [7:0]    byte_a_q;
	logic [7:0]    byte_b_q;
	logic          two_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;
	logic [7:0]    digit_stack [11];

	logic          accept;
	logic          slot_free;
	logic          emit;
	logic [7:0]    emit_byte;
	logic          emit_last;

	logic          c_nul, c_pct, c_dig, c_d, c_hex, c_chr, c_num;
	logic [PW+3:0] pad_w;
	logic [PW-1:0] pad_sat;
	logic [63:0]   prod;
	logic [31:0]   rem_dec;
	logic [3:0]    digit;
	logic [31:0]   next_x;
	logic          dig_done;
	logic [3:0]    cnt_fin;
	logic          pad_needed;

	// Decode the incoming format word
	assign c_nul = (fmt_char == fsp_pkg::CH_NUL);
	assign c_pct = (fmt_char == fsp_pkg::CH_PCT);
	assign c_dig = (fmt_char >= fsp_pkg::CH_0) && (fmt_char <= fsp_pkg::CH_9);
	assign c_d   = (fmt_char == fsp_pkg::CH_D);
	assign c_hex = (fmt_char == fsp_pkg::CH_X) || (fmt_char == fsp_pkg::CH_P);
	assign c_chr = (fmt_char == fsp_pkg::CH_C);
	assign c_num = c_d || c_hex;

	assign accept = in_valid && !in_stall;

	// Width accumulation: pad*10 + digit, saturated
	assign pad_w   = ({4'b0000, pad_q} << 3) + ({4'b0000, pad_q} << 1)
		+ (PW+4)'(fmt_char[3:0]);
	assign pad_sat = (pad_w > (PW+4)'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : pad_w[PW-1:0];

	// Shared digit unit: reciprocal multiply, then remainder by shift-add
	assign prod     = 64'(x_q) * 64'(fsp_pkg::RECIP10);
	assign rem_dec  = x_q - ((32'(quo_q) << 3) + (32'(quo_q) << 1));
	assign digit    = hex_q ? x_q[3:0] : rem_dec[3:0];
	assign next_x   = hex_q ? {4'b0000, x_q[31:4]} : 32'(quo_q);
	assign dig_done = (next_x == 32'd0) || (cnt_q == fsp_pkg::NUM_DIGITS - 4'd1);

	// Length of the number once the sign is pushed
	assign cnt_fin    = cnt_q + {3'b000, neg_q};
	assign pad_needed = (pw_q > PW'(cnt_fin));

	assign slot_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsp_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (c_nul)
						state_d = fsp_pkg::ST_CHAR1;
					else if (!after_q)
						state_d = c_pct ? fsp_pkg::ST_IDLE : fsp_pkg::ST_CHAR1;
					else if (c_dig)
						state_d = fsp_pkg::ST_IDLE;
					else if (c_d)
						state_d = fsp_pkg::ST_MUL;
					else if (c_hex)
						state_d = fsp_pkg::ST_DIG;
					else
						state_d = fsp_pkg::ST_CHAR1;
				end
			end
			fsp_pkg::ST_CHAR1: begin
				if (emit)
					state_d = two_q ? fsp_pkg::ST_CHAR2 : fsp_pkg::ST_IDLE;
			end
			fsp_pkg::ST_CHAR2: begin
				if (emit)
					state_d = fsp_pkg::ST_IDLE;
			end
			fsp_pkg::ST_MUL: state_d = fsp_pkg::ST_DIG;
			fsp_pkg::ST_DIG: begin
				if (dig_done)
					state_d = fsp_pkg::ST_FIN;
				else
					state_d = hex_q ? fsp_pkg::ST_DIG : fsp_pkg::ST_MUL;
			end
			fsp_pkg::ST_FIN: state_d = pad_needed ? fsp_pkg::ST_PAD : fsp_pkg::ST_OUT;
			fsp_pkg::ST_PAD: begin
				if (emit && pad_rem_q == PW'(1))
					state_d = fsp_pkg::ST_OUT;
			end
			fsp_pkg::ST_OUT: begin
				if (emit && cnt_q == 4'd1)
					state_d = fsp_pkg::ST_IDLE;
			end
			default: state_d = fsp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != fsp_pkg::ST_IDLE);
		emit      = 1'b0;
		emit_byte = byte_a_q;
		emit_last = 1'b1;
		unique case (state_q)
			fsp_pkg::ST_CHAR1: begin
				emit      = slot_free;
				emit_byte = byte_a_q;
				emit_last = !two_q;
			end
			fsp_pkg::ST_CHAR2: begin
				emit      = slot_free;
				emit_byte = byte_b_q;
				emit_last = 1'b1;
			end
			fsp_pkg::ST_PAD: begin
				emit      = slot_free;
				emit_byte = fsp_pkg::CH_0;
				emit_last = 1'b0;
			end
			fsp_pkg::ST_OUT: begin
				emit      = slot_free;
				emit_byte = digit_stack[cnt_q - 4'd1];
				emit_last = (cnt_q == 4'd1);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsp_pkg::ST_IDLE;
			after_q     <= 1'b0;
			pad_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Track the conversion prefix and its width
			if (accept) begin
				priority if (c_nul) begin
					after_q <= 1'b0;
					pad_q   <= '0;
				end else if (!after_q) begin
					after_q <= c_pct;
				end else if (c_dig) begin
					pad_q <= pad_sat;
				end else begin
					after_q <= 1'b0;
					pad_q   <= '0;
				end
			end
			// Count digits up while converting, down while sending
			priority if (accept)
				cnt_q <= '0;
			else if (state_q == fsp_pkg::ST_DIG)
				cnt_q <= cnt_q + 4'd1;
			else if (state_q == fsp_pkg::ST_FIN)
				cnt_q <= cnt_fin;
			else if (state_q == fsp_pkg::ST_OUT && emit)
				cnt_q <= cnt_q - 4'd1;
			// Hold the output word while stalled
			if (slot_free)
				out_valid_q <= emit;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_a_q <= (after_q && c_chr) ? arg_value[7:0]
				: (after_q && !c_nul) ? fsp_pkg::CH_PCT : fmt_char;
			byte_b_q <= fmt_char;
			two_q    <= after_q && !c_nul && !c_dig && !c_num && !c_chr && !c_pct;
			neg_q    <= c_d && arg_value[31];
			hex_q    <= c_hex;
			x_q      <= (c_d && arg_value[31]) ? (32'd0 - arg_value) : arg_value;
			pw_q     <= pad_q;
		end
		if (state_q == fsp_pkg::ST_MUL)
			quo_q <= prod[63:fsp_pkg::RECIP10_SHIFT];
		// Push one digit per pass through the digit unit
		if (state_q == fsp_pkg::ST_DIG) begin
			digit_stack[cnt_q] <= fsp_pkg::hex_ascii(digit);
			x_q <= next_x;
		end
		// Push the sign and set the pad count
		if (state_q == fsp_pkg::ST_FIN) begin
			if (neg_q)
				digit_stack[cnt_q] <= fsp_pkg::CH_MINUS;
			pad_rem_q <= pad_needed ? (pw_q - PW'(cnt_fin)) : '0;
		end
		if (state_q == fsp_pkg::ST_PAD && emit)
			pad_rem_q <= pad_rem_q - PW'(1);
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

`default_nettype wire

FILE: rtl/fsp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  fmt_char,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        last
);

	// A stalled output word holds
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last), "held word moved")

	// A terminator always produces a word, so the block goes busy
	`ASSERT_NEXT(a_nul_busy, in_valid && !in_stall && fmt_char == fsp_pkg::CH_NUL, in_stall, "no output on terminator")

	// Going idle coincides with presenting the final word
	`ASSERT_SAME(a_idle_last, $fell(in_stall), out_valid && last, "went idle without final word")

	// A non-final word means the item is still in progress
	`ASSERT_SAME(a_mid_busy, out_valid && !last, in_stall, "idle while item incomplete")

endmodule

bind format_string_printer fsp_checker u_fsp_checker (.*);

`default_nettype wire

FILE: bench/format_string_printer_tb.sv
`default_nettype none

module format_string_printer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789ABCDEF";

	typedef struct packed {
		logic [7:0]  ch;
		logic [31:0] arg;
	} fmt_word_t;

	typedef struct packed {
		logic [7:0] code;
		logic       tail;
	} print_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  fmt_char = 8'h00;
	logic [31:0] arg_value = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	fmt_word_t   fmt_words[$];
	print_byte_t printed_bytes[$];

	// Shadow of the conversion state
	logic       in_conv = 1'b0;
	logic [6:0] pad_w = 7'd0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int errors = 0;
	int words_sent = 0;
	int bytes_seen = 0;

	format_string_printer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.fmt_char  (fmt_char),
		.arg_value (arg_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the bytes one format word prints and advance the shadow state
	function automatic void print_word(input logic [7:0] c, input logic [31:0] arg);
		logic [7:0]  line[$];
		logic [7:0]  digs[11];
		logic [31:0] mag;
		logic [31:0] base;
		logic        neg;
		int          cnt;
		int          w;
		int          i;
		print_byte_t pb;
		if (c == fsp_pkg::CH_NUL) begin
			line.push_back(fsp_pkg::CH_NUL);
			in_conv = 1'b0;
			pad_w = 7'd0;
		end else if (!in_conv) begin
			if (c == fsp_pkg::CH_PCT)
				in_conv = 1'b1;
			else
				line.push_back(c);
		end else if (c >= fsp_pkg::CH_0 && c <= fsp_pkg::CH_9) begin
			w = int'(pad_w) * 10 + int'(c - fsp_pkg::CH_0);
			if (w > fsp_pkg::MAX_WIDTH_DEF)
				w = fsp_pkg::MAX_WIDTH_DEF;
			pad_w = 7'(w);
		end else begin
			if (c == fsp_pkg::CH_D || c == fsp_pkg::CH_X || c == fsp_pkg::CH_P) begin
				base = (c == fsp_pkg::CH_D) ? 32'd10 : 32'd16;
				neg = (c == fsp_pkg::CH_D) && arg[31];
				mag = neg ? 32'(32'd0 - arg) : arg;
				cnt = 0;
				do begin
					digs[cnt] = DIGIT_GLYPHS[8 * (15 - int'(mag % base)) +: 8];
					cnt++;
					mag = mag / base;
				end while (mag != 0);
				if (neg) begin
					digs[cnt] = fsp_pkg::CH_MINUS;
					cnt++;
				end
				// zeros go ahead of the sign
				for (i = cnt; i < int'(pad_w); i++)
					line.push_back(fsp_pkg::CH_0);
				for (i = cnt - 1; i >= 0; i--)
					line.push_back(digs[i]);
			end else if (c == fsp_pkg::CH_C) begin
				line.push_back(arg[7:0]);
			end else if (c == fsp_pkg::CH_PCT) begin
				line.push_back(fsp_pkg::CH_PCT);
			end else begin
				line.push_back(fsp_pkg::CH_PCT);
				line.push_back(c);
			end
			in_conv = 1'b0;
			pad_w = 7'd0;
		end
		for (i = 0; i < line.size() && i < 64; i++) begin
			pb.code = line[i];
			pb.tail = (i == line.size() - 1) || (i == 63);
			printed_bytes.push_back(pb);
		end
	endfunction

	// Send side: hold a word until taken, then offer the next or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				print_word(fmt_char, arg_value);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (fmt_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					fmt_char <= fmt_words[0].ch;
					arg_value <= fmt_words[0].arg;
					void'(fmt_words.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receive side: random stall, or a long hold on request
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check each printed byte against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			bytes_seen++;
			if (printed_bytes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected byte %h last=%b", $realtime, out_byte, last);
			end else begin
				if (out_byte !== printed_bytes[0].code || last !== printed_bytes[0].tail) begin
					errors++;
					if (errors <= 10)
						$display("%0t: byte mismatch: expected %h last=%b, got %h last=%b",
							$realtime, printed_bytes[0].code, printed_bytes[0].tail,
							out_byte, last);
				end
				void'(printed_bytes.pop_front());
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic queue_word(input logic [7:0] c, input logic [31:0] arg);
		fmt_word_t fw;
		fw.ch = c;
		fw.arg = arg;
		fmt_words.push_back(fw);
	endtask

	function automatic logic [31:0] pick_arg();
		case ($urandom_range(5))
			0: return 32'($urandom_range(9));
			1: return 32'(32'd0 - 32'($urandom_range(1, 300)));
			2: return 32'h8000_0000 | 32'($urandom_range(1));
			3: return 32'h7FFF_FFFF - 32'($urandom_range(1));
			default: return $urandom();
		endcase
	endfunction

	// Append one random piece of format string, mostly well formed
	task automatic queue_piece();
		int         r;
		int         ndig;
		int         k;
		logic [7:0] cv;
		r = $urandom_range(99);
		if (r < 10) begin
			queue_word(8'($urandom_range(255)), $urandom());
		end else if (r < 18) begin
			queue_word(fsp_pkg::CH_NUL, $urandom());
		end else if (r < 42) begin
			queue_word(8'($urandom_range(1, 255)), $urandom());
		end else begin
			queue_word(fsp_pkg::CH_PCT, $urandom());
			r = $urandom_range(99);
			ndig = (r < 50) ? 0 : (r < 85) ? 1 : (r < 97) ? 2 : 3;
			for (k = 0; k < ndig; k++)
				queue_word(fsp_pkg::CH_0 + 8'($urandom_range(9)), $urandom());
			r = $urandom_range(99);
			if (r < 30) begin
				cv = fsp_pkg::CH_D;
			end else if (r < 50) begin
				cv = fsp_pkg::CH_X;
			end else if (r < 60) begin
				cv = fsp_pkg::CH_P;
			end else if (r < 75) begin
				cv = fsp_pkg::CH_C;
			end else if (r < 85) begin
				cv = fsp_pkg::CH_PCT;
			end else begin
				do
					cv = 8'($urandom_range(1, 255));
				while (cv >= fsp_pkg::CH_0 && cv <= fsp_pkg::CH_9);
			end
			queue_word(cv, pick_arg());
		end
	endtask

	task automatic queue_pieces(input int count);
		int start;
		start = fmt_words.size();
		while (fmt_words.size() - start < count)
			queue_piece();
	endtask

	// Wait until every queued word is taken and every byte is back
	task automatic drain();
		while (fmt_words.size() != 0 || in_valid || printed_bytes.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, each conversion, corner cases
		queue_word("A", $urandom());
		queue_word(8'hFF, $urandom());
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_D, 32'h0);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_D, 32'h8000_0000);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word("5", 32'h0);
		queue_word(fsp_pkg::CH_D, 32'hFFFF_FFFB);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_X, 32'hFFFF_FFFF);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word("9", 32'h0);
		queue_word("9", 32'h0);
		queue_word(fsp_pkg::CH_P, 32'h0);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_C, 32'h1234_56C1);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word("s", 32'h0);
		queue_word(fsp_pkg::CH_PCT, 32'h0);
		queue_word("3", 32'h0);
		queue_word(fsp_pkg::CH_NUL, 32'h0);
		queue_word(fsp_pkg::CH_NUL, 32'hFFFF_FFFF);
		queue_pieces(55);
		drain();

		// Long receiver hold while the sender keeps offering
		queue_pieces(40);
		@(negedge clk);
		hold_ask = hold_ask + 1;
		drain();

		send_idle_pct = 79;
		queue_pieces(55);
		drain();

		send_idle_pct = 0;
		stall_pct = 79;
		queue_pieces(55);
		drain();

		send_idle_pct = 23;
		stall_pct = 23;
		queue_pieces(55);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (printed_bytes.size() != 0) begin
			errors++;
			$display("%0d predicted bytes never printed", printed_bytes.size());
		end
		$display("Sent %0d format words and checked %0d printed bytes", words_sent, bytes_seen);
		$display("under free-running, sender-idle, receiver-stall and long-hold traffic");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
